// ----- rtl/pse_pkg.sv -----
// shared types, codes and saturation helpers for the postfix stack evaluator
// no dependencies; used by every file under rtl

package pse_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int WORD_W          = 32;
	localparam int FRAC_W          = 16;
	// quotient bits left to find once the top bits are known to be zero
	localparam int DIV_STEPS       = WORD_W - 1;
	localparam int MAG_W           = WORD_W + FRAC_W;

	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_APPLY  = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	localparam logic [7:0] CH_ADD = 8'h2B;
	localparam logic [7:0] CH_SUB = 8'h2D;
	localparam logic [7:0] CH_MUL = 8'h2A;
	localparam logic [7:0] CH_DIV = 8'h2F;

	typedef enum logic [2:0] {
		STS_OK      = 3'd0,
		STS_UNDER   = 3'd1,
		STS_DIVZERO = 3'd2,
		STS_BADOP   = 3'd3,
		STS_OVER    = 3'd4,
		STS_EXTRA   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		PS_IDLE,
		PS_EXEC,
		PS_MUL,
		PS_DIV,
		PS_WRITE
	} state_t;

	typedef struct packed {
		logic [1:0]               op;
		logic signed [WORD_W-1:0] operand_value;
		logic [7:0]               operator_char;
	} pse_in_t;

	typedef struct packed {
		status_t                  status;
		logic signed [WORD_W-1:0] result_value;
		logic                     result_valid;
	} pse_out_t;

	typedef struct packed {
		logic push;
		logic pop;
	} pse_cell_ctl_t;

	function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] n;
		n = -x;
		return x[WORD_W-1] ? n : x;
	endfunction

	function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W:0] s);
		logic [WORD_W-1:0] r;
		if (s[WORD_W] != s[WORD_W-1]) begin
			r = s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
		end else begin
			r = s[WORD_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] sat_mag(input logic neg, input logic [MAG_W-1:0] m);
		logic [MAG_W-1:0]  nm;
		logic [MAG_W-1:0]  lim;
		logic [WORD_W-1:0] r;
		nm  = -m;
		lim = MAG_W'({1'b1, {(WORD_W-1){1'b0}}});
		if (neg) begin
			r = (m >= lim) ? {1'b1, {(WORD_W-1){1'b0}}} : nm[WORD_W-1:0];
		end else begin
			r = (m >= lim) ? {1'b0, {(WORD_W-1){1'b1}}} : m[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/pse_cell.sv -----
// one stack cell: holds a word, takes it from the cell above on push
// or from the cell below on pop; depends on pse_pkg

module pse_cell (
	input  logic                          clk,
	input  pse_pkg::pse_cell_ctl_t        ctl,
	input  logic [pse_pkg::WORD_W-1:0]    d_push,
	input  logic [pse_pkg::WORD_W-1:0]    d_pop,
	output logic [pse_pkg::WORD_W-1:0]    q
);

	logic [pse_pkg::WORD_W-1:0] word_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			word_q <= d_push;
		end else if (ctl.pop) begin
			word_q <= d_pop;
		end
	end

	assign q = word_q;

endmodule

// ----- rtl/pse_div.sv -----
// iterative restoring divider for the q16.16 quotient magnitude, one bit a cycle
// reports a saturating magnitude; depends on pse_pkg

module pse_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pse_pkg::WORD_W-1:0]    dividend_mag,
	input  logic [pse_pkg::WORD_W-1:0]    divisor_mag,
	output logic                          done,
	output logic [pse_pkg::MAG_W-1:0]     quot_mag
);

	localparam int W    = pse_pkg::WORD_W;
	localparam int F    = pse_pkg::FRAC_W;
	localparam int N    = pse_pkg::DIV_STEPS;
	localparam int CNTW = $clog2(N);
	// remainder seed takes the dividend bits above the ones still to come
	localparam int SEEDW = pse_pkg::MAG_W - N;

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [W-1:0]    rem_q;
	logic [N-1:0]    low_q;
	logic [N-1:0]    quo_q;
	logic [W-1:0]    div_q;
	logic            ovf_q;
	logic [W:0]      trial;
	logic [W:0]      diff;
	logic            ge;

	assign trial = {rem_q, low_q[N-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNTW'(N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= W'(dividend_mag[W-1:W-SEEDW]);
			low_q <= {dividend_mag[W-SEEDW-1:0], {F{1'b0}}};
			quo_q <= '0;
			div_q <= divisor_mag;
			// quotient of 2^31 or more saturates whatever the low bits are
			ovf_q <= ({{(N-F){1'b0}}, dividend_mag} >= {divisor_mag, {(N-F){1'b0}}});
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			low_q <= {low_q[N-2:0], 1'b0};
			quo_q <= {quo_q[N-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quot_mag = ovf_q ? {pse_pkg::MAG_W{1'b1}} : {{(pse_pkg::MAG_W-N){1'b0}}, quo_q};

endmodule

// ----- rtl/postfix_stack_evaluator.sv -----
// postfix evaluator on a shift-register stack of q16.16 words; uses pse_pkg, pse_cell, pse_div
// a token is registered in idle; push, add, subtract, finish and every error load the output
// register from exec, multiply through the mul and write states, divide (31 divider steps)
// through the div and write states; a new token is taken once the previous one has left the
// datapath; the output register lets a token in while a result waits
// arst_n clears the control state and the stack count; stack words hold no reset

module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_valid,
	output logic              tok_ready,
	input  pse_pkg::pse_in_t  tok,
	output logic              res_valid,
	input  logic              res_ready,
	output pse_pkg::pse_out_t res
);

	localparam int W  = pse_pkg::WORD_W;
	localparam int F  = pse_pkg::FRAC_W;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	pse_pkg::state_t   state_q, state_nxt;
	pse_pkg::pse_in_t  tok_q;
	pse_pkg::pse_out_t res_q, out_next;
	logic              res_valid_q;
	logic [CW-1:0]     count_q;

	// stack cells, cell 0 is the top of stack
	logic [W-1:0]           cell_q [STACK_DEPTH];
	pse_pkg::pse_cell_ctl_t cell_ctl;
	logic [W-1:0]           top_d;

	// decode of the token held in exec
	logic out_free, out_load, imm, go_mul, go_div;
	logic cnt_clr, cnt_inc, cnt_dec;

	// arithmetic operands and results
	logic [W-1:0]            right_w, left_w;
	logic [W-1:0]            mag_l, mag_r;
	logic                    neg_w;
	logic [W-1:0]            mag_l_q, mag_r_q;
	logic                    neg_q, is_div_q;
	logic [2*W-1:0]          prod_s1;
	logic [pse_pkg::MAG_W-1:0] div_m;
	logic                    div_done;
	logic [W-1:0]            sum_w, dif_w, arith_w;

	assign right_w = cell_q[0];
	assign left_w  = cell_q[1];
	assign mag_l   = pse_pkg::mag32(left_w);
	assign mag_r   = pse_pkg::mag32(right_w);
	assign neg_w   = left_w[W-1] ^ right_w[W-1];
	assign sum_w   = pse_pkg::sat_add({left_w[W-1], left_w} + {right_w[W-1], right_w});
	assign dif_w   = pse_pkg::sat_add({left_w[W-1], left_w} - {right_w[W-1], right_w});
	assign arith_w = is_div_q ? pse_pkg::sat_mag(neg_q, div_m)
	                          : pse_pkg::sat_mag(neg_q, prod_s1[2*W-1:F]);

	assign out_free = !res_valid_q || res_ready;

	// ---------------------------------------------------------------- stack row
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [W-1:0] d_push, d_pop;
		if (i == 0) begin : g_top
			assign d_push = top_d;
			assign d_pop  = top_d;
		end else begin : g_mid
			assign d_push = cell_q[i-1];
			if (i == STACK_DEPTH - 1) begin : g_last
				assign d_pop = '0;
			end else begin : g_inner
				assign d_pop = cell_q[i+1];
			end
		end
		pse_cell u_cell (
			.clk    (clk),
			.ctl    (cell_ctl),
			.d_push (d_push),
			.d_pop  (d_pop),
			.q      (cell_q[i])
		);
	end

	// ---------------------------------------------------------------- divider
	pse_div u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (go_div),
		.dividend_mag (mag_l),
		.divisor_mag  (mag_r),
		.done         (div_done),
		.quot_mag     (div_m)
	);

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			pse_pkg::PS_IDLE: begin
				if (tok_valid) state_nxt = pse_pkg::PS_EXEC;
			end
			pse_pkg::PS_EXEC: begin
				if (go_mul) begin
					state_nxt = pse_pkg::PS_MUL;
				end else if (go_div) begin
					state_nxt = pse_pkg::PS_DIV;
				end else if (out_load) begin
					state_nxt = pse_pkg::PS_IDLE;
				end
			end
			pse_pkg::PS_MUL:   state_nxt = pse_pkg::PS_WRITE;
			pse_pkg::PS_DIV: begin
				if (div_done) state_nxt = pse_pkg::PS_WRITE;
			end
			pse_pkg::PS_WRITE: begin
				if (out_free) state_nxt = pse_pkg::PS_IDLE;
			end
			default:           state_nxt = pse_pkg::PS_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- outputs and decode
	always_comb begin
		tok_ready             = (state_q == pse_pkg::PS_IDLE);
		imm                   = 1'b0;
		go_mul                = 1'b0;
		go_div                = 1'b0;
		out_load              = 1'b0;
		cnt_clr               = 1'b0;
		cnt_inc               = 1'b0;
		cnt_dec               = 1'b0;
		cell_ctl              = '0;
		top_d                 = tok_q.operand_value;
		out_next.status       = pse_pkg::STS_OK;
		out_next.result_value = '0;
		out_next.result_valid = 1'b0;

		case (state_q)
			pse_pkg::PS_EXEC: begin
				case (tok_q.op)
					pse_pkg::OP_PUSH: begin
						imm = 1'b1;
						if (count_q >= CW'(STACK_DEPTH)) begin
							out_next.status = pse_pkg::STS_OVER;
							cnt_clr         = out_free;
						end else begin
							cell_ctl.push = out_free;
							cnt_inc       = out_free;
						end
					end
					pse_pkg::OP_APPLY: begin
						if (count_q < CW'(2)) begin
							// too few operands, checked before the operator
							imm             = 1'b1;
							out_next.status = pse_pkg::STS_UNDER;
							cnt_clr         = out_free;
						end else begin
							case (tok_q.operator_char)
								pse_pkg::CH_ADD: begin
									imm          = 1'b1;
									top_d        = sum_w;
									cell_ctl.pop = out_free;
									cnt_dec      = out_free;
								end
								pse_pkg::CH_SUB: begin
									imm          = 1'b1;
									top_d        = dif_w;
									cell_ctl.pop = out_free;
									cnt_dec      = out_free;
								end
								pse_pkg::CH_MUL: go_mul = 1'b1;
								pse_pkg::CH_DIV: begin
									if (right_w == '0) begin
										imm             = 1'b1;
										out_next.status = pse_pkg::STS_DIVZERO;
										cnt_clr         = out_free;
									end else begin
										go_div = 1'b1;
									end
								end
								default: begin
									imm             = 1'b1;
									out_next.status = pse_pkg::STS_BADOP;
									cnt_clr         = out_free;
								end
							endcase
						end
					end
					pse_pkg::OP_FINISH: begin
						imm     = 1'b1;
						cnt_clr = out_free;
						if (count_q == '0) begin
							out_next.status = pse_pkg::STS_UNDER;
						end else if (count_q != CW'(1)) begin
							out_next.status = pse_pkg::STS_EXTRA;
						end else begin
							out_next.result_value = right_w;
							out_next.result_valid = 1'b1;
						end
					end
					default: imm = 1'b1;   // unused op code: empty result, state kept
				endcase
				out_load = imm && out_free;
			end
			pse_pkg::PS_WRITE: begin
				// the two operands leave, the result takes the top cell
				top_d        = arith_w;
				cell_ctl.pop = out_free;
				cnt_dec      = out_free;
				out_load     = out_free;
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pse_pkg::PS_IDLE;
			res_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			state_q <= state_nxt;
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (cnt_clr) begin
				count_q <= '0;
			end else if (cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- payload registers
	always_ff @(posedge clk) begin
		if (tok_valid && tok_ready) tok_q <= tok;
		if (out_load)               res_q <= out_next;
		if (go_mul || go_div) begin
			mag_l_q  <= mag_l;
			mag_r_q  <= mag_r;
			neg_q    <= neg_w;
			is_div_q <= go_div;
		end
		// multiplier stage, saturated in the write state
		if (state_q == pse_pkg::PS_MUL) prod_s1 <= mag_l_q * mag_r_q;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- rtl/pse_chk.sv -----
// port-level checks for the postfix stack evaluator, bound to the top level
// depends on pse_pkg and postfix_stack_evaluator

module pse_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              tok_valid,
	input logic              tok_ready,
	input logic              res_valid,
	input logic              res_ready,
	input pse_pkg::pse_out_t res
);

	// a waiting result holds until its transfer
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// one token at a time: busy right after a token transfer
	a_busy_after_tok: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_ready |=> !tok_ready)
		else $error("token taken while previous token in flight");

	// a returned value only comes with a good status
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.result_valid |-> res.status == pse_pkg::STS_OK)
		else $error("result value flagged with an error status");

	// no value leaks out of tokens other than a good finish
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.result_valid |-> res.result_value == '0)
		else $error("nonzero value without result_valid");

endmodule

bind postfix_stack_evaluator pse_chk u_pse_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.tok_valid (tok_valid),
	.tok_ready (tok_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
